// ===== hdl/assert_macros.svh =====
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only outside reset
`define ASSERT_HOLD(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/pmt_pkg.sv =====
package pmt_pkg;

  // result kinds
  typedef enum logic {
    KIND_ENTRY   = 1'b0,
    KIND_SUMMARY = 1'b1
  } pmt_kind_t;

  // byte positions within the section header
  localparam logic [12:0] POS_LEN_HI    = 13'd1;
  localparam logic [12:0] POS_LEN_LO    = 13'd2;
  localparam logic [12:0] POS_PROG_HI   = 13'd3;
  localparam logic [12:0] POS_PROG_LO   = 13'd4;
  localparam logic [12:0] POS_VERSION   = 13'd5;
  localparam logic [12:0] POS_SECT_NUM  = 13'd6;
  localparam logic [12:0] POS_LAST_SECT = 13'd7;
  localparam logic [12:0] POS_PCR_HI    = 13'd8;
  localparam logic [12:0] POS_PCR_LO    = 13'd9;
  localparam logic [12:0] POS_INFO_HI   = 13'd10;
  localparam logic [12:0] POS_INFO_LO   = 13'd11;
  localparam logic [12:0] POS_BODY      = 13'd12;

  // shortest section length that holds header and crc
  localparam logic [11:0] MIN_SECTION_LEN = 12'd13;

  // byte index within one elementary stream entry
  localparam logic [2:0] ENT_TYPE    = 3'd0;
  localparam logic [2:0] ENT_PID_HI  = 3'd1;
  localparam logic [2:0] ENT_PID_LO  = 3'd2;
  localparam logic [2:0] ENT_INFO_HI = 3'd3;
  localparam logic [2:0] ENT_INFO_LO = 3'd4;

  // default depth of the result queue
  localparam int unsigned RESULT_DEPTH = 2;

  typedef struct packed {
    pmt_kind_t   kind;
    logic [7:0]  entry_index;
    logic [7:0]  es_type;
    logic [12:0] es_pid;
    logic [15:0] prog_num;
    logic [4:0]  version_num;
    logic        current_next;
    logic [7:0]  sect_num;
    logic [7:0]  last_sect_num;
    logic [12:0] pcr_pid;
    logic [31:0] crc_value;
    logic        malformed;
  } pmt_result_t;

endpackage

// ===== hdl/pmt_channels.sv =====
// section byte channel
interface pmt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       section_start;

  modport source (output valid, byte_value, section_start, input ready);
  modport sink (input valid, byte_value, section_start, output ready);
endinterface

// parsed result channel
interface pmt_result_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  entry_index;
  logic [7:0]  es_type;
  logic [12:0] es_pid;
  logic [15:0] prog_num;
  logic [4:0]  version_num;
  logic        current_next;
  logic [7:0]  sect_num;
  logic [7:0]  last_sect_num;
  logic [12:0] pcr_pid;
  logic [31:0] crc_value;
  logic        malformed;

  modport source (
    output valid, kind, entry_index, es_type, es_pid, prog_num,
      version_num, current_next, sect_num, last_sect_num, pcr_pid,
      crc_value, malformed,
    input ready
  );
  modport sink (
    input valid, kind, entry_index, es_type, es_pid, prog_num,
      version_num, current_next, sect_num, last_sect_num, pcr_pid,
      crc_value, malformed,
    output ready
  );
endinterface

// ===== hdl/pmt_parse.sv =====
module pmt_parse (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          byte_value,
  input  logic                section_start,
  output logic                res_valid,
  output pmt_pkg::pmt_result_t res
);
  import pmt_pkg::*;

  // section state
  logic        active, active_next;
  logic [12:0] byte_position, byte_position_next;
  logic [11:0] sect_len, sect_len_next;
  logic [11:0] skip_remaining, skip_remaining_next;
  logic [2:0]  entry_byte, entry_byte_next;
  logic [7:0]  entry_type, entry_type_next;
  logic [12:0] entry_pid, entry_pid_next;
  logic [3:0]  entry_info_hi, entry_info_hi_next;
  logic [7:0]  entry_count, entry_count_next;
  logic [15:0] prog_num, prog_num_next;
  logic [4:0]  version_num, version_num_next;
  logic        current_next, current_next_next;
  logic [7:0]  sect_num, sect_num_next;
  logic [7:0]  last_section, last_section_next;
  logic [12:0] pcr_pid, pcr_pid_next;
  logic [31:0] crc_hold, crc_hold_next;
  logic        malformed, malformed_next;

  // per-byte decode; a start byte sees a cleared section
  always_comb begin
    logic        start;
    logic [12:0] pos;
    logic [13:0] pos_plus1;
    logic [12:0] end_pos;
    logic        in_crc;

    start = take && section_start;
    active_next         = active;
    byte_position_next  = start ? '0 : byte_position;
    sect_len_next       = start ? '0 : sect_len;
    skip_remaining_next = start ? '0 : skip_remaining;
    entry_byte_next     = start ? ENT_TYPE : entry_byte;
    entry_type_next     = start ? '0 : entry_type;
    entry_pid_next      = start ? '0 : entry_pid;
    entry_info_hi_next  = start ? '0 : entry_info_hi;
    entry_count_next    = start ? '0 : entry_count;
    prog_num_next       = start ? '0 : prog_num;
    version_num_next    = start ? '0 : version_num;
    current_next_next   = start ? 1'b0 : current_next;
    sect_num_next       = start ? '0 : sect_num;
    last_section_next   = start ? '0 : last_section;
    pcr_pid_next        = start ? '0 : pcr_pid;
    crc_hold_next       = start ? '0 : crc_hold;
    malformed_next      = start ? 1'b0 : malformed;
    res_valid = 1'b0;
    res       = '0;
    pos       = byte_position_next;
    pos_plus1 = {1'b0, pos} + 14'd1;
    in_crc    = 1'b0;
    end_pos   = '0;

    if (take && (start || active)) begin
      active_next   = 1'b1;
      crc_hold_next = {crc_hold_next[23:0], byte_value};

      // header fields by position
      if (pos == POS_LEN_HI) begin
        sect_len_next = {byte_value[3:0], 8'h00};
      end else if (pos == POS_LEN_LO) begin
        sect_len_next = {sect_len_next[11:8], byte_value};
        if ({sect_len_next[11:8], byte_value} < MIN_SECTION_LEN) begin
          malformed_next = 1'b1;
        end
      end else if (pos == POS_PROG_HI) begin
        prog_num_next[15:8] = byte_value;
      end else if (pos == POS_PROG_LO) begin
        prog_num_next[7:0] = byte_value;
      end else if (pos == POS_VERSION) begin
        version_num_next  = byte_value[5:1];
        current_next_next = byte_value[0];
      end else if (pos == POS_SECT_NUM) begin
        sect_num_next = byte_value;
      end else if (pos == POS_LAST_SECT) begin
        last_section_next = byte_value;
      end else if (pos == POS_PCR_HI) begin
        pcr_pid_next[12:8] = byte_value[4:0];
      end else if (pos == POS_PCR_LO) begin
        pcr_pid_next[7:0] = byte_value;
      end else if (pos == POS_INFO_HI) begin
        skip_remaining_next = {byte_value[3:0], 8'h00};
      end else if (pos == POS_INFO_LO) begin
        skip_remaining_next = {skip_remaining_next[11:8], byte_value};
        entry_byte_next     = ENT_TYPE;
      end else if (pos >= POS_BODY) begin
        in_crc = pos_plus1 >= {2'b00, sect_len_next};
        if (in_crc) begin
          // crc region: pending descriptors or a partial entry are an overrun
          if (skip_remaining_next != '0 || entry_byte_next != ENT_TYPE) begin
            malformed_next = 1'b1;
          end
          skip_remaining_next = '0;
          entry_byte_next     = ENT_TYPE;
        end else if (skip_remaining_next != '0) begin
          skip_remaining_next = skip_remaining_next - 12'd1;
        end else begin
          // elementary stream entry bytes
          case (entry_byte_next)
            ENT_TYPE: begin
              entry_type_next = byte_value;
              entry_byte_next = ENT_PID_HI;
            end
            ENT_PID_HI: begin
              entry_pid_next  = {byte_value[4:0], 8'h00};
              entry_byte_next = ENT_PID_LO;
            end
            ENT_PID_LO: begin
              entry_pid_next  = {entry_pid_next[12:8], byte_value};
              entry_byte_next = ENT_INFO_HI;
            end
            ENT_INFO_HI: begin
              entry_info_hi_next = byte_value[3:0];
              entry_byte_next    = ENT_INFO_LO;
            end
            default: begin
              res_valid            = 1'b1;
              res.kind             = KIND_ENTRY;
              res.entry_index      = entry_count_next;
              res.es_type          = entry_type_next;
              res.es_pid           = entry_pid_next;
              entry_count_next     = entry_count_next + 8'd1;
              skip_remaining_next  = {entry_info_hi_next, byte_value};
              entry_byte_next      = ENT_TYPE;
            end
          endcase
        end
      end

      // last crc byte closes the section
      end_pos = {1'b0, sect_len_next} + 13'd2;
      if (pos >= POS_LEN_LO && pos == end_pos) begin
        res_valid         = 1'b1;
        res               = '0;
        res.kind          = KIND_SUMMARY;
        res.entry_index   = entry_count_next;
        res.prog_num      = prog_num_next;
        res.version_num   = version_num_next;
        res.current_next  = current_next_next;
        res.sect_num      = sect_num_next;
        res.last_sect_num = last_section_next;
        res.pcr_pid       = pcr_pid_next;
        res.crc_value     = crc_hold_next;
        res.malformed     = malformed_next;
        active_next       = 1'b0;
      end

      byte_position_next = pos + 13'd1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      active         <= 1'b0;
      byte_position  <= '0;
      sect_len       <= '0;
      skip_remaining <= '0;
      entry_byte     <= ENT_TYPE;
      entry_count    <= '0;
      malformed      <= 1'b0;
    end else begin
      active         <= active_next;
      byte_position  <= byte_position_next;
      sect_len       <= sect_len_next;
      skip_remaining <= skip_remaining_next;
      entry_byte     <= entry_byte_next;
      entry_count    <= entry_count_next;
      malformed      <= malformed_next;
    end
  end

  // field holds, cleared by the start byte
  always_ff @(posedge clk) begin
    entry_type    <= entry_type_next;
    entry_pid     <= entry_pid_next;
    entry_info_hi <= entry_info_hi_next;
    prog_num      <= prog_num_next;
    version_num   <= version_num_next;
    current_next  <= current_next_next;
    sect_num      <= sect_num_next;
    last_section  <= last_section_next;
    pcr_pid       <= pcr_pid_next;
    crc_hold      <= crc_hold_next;
  end

endmodule

// ===== hdl/pmt_result_fifo.sv =====
module pmt_result_fifo #(
  parameter int unsigned DEPTH = pmt_pkg::RESULT_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  pmt_pkg::pmt_result_t push_data,
  output logic                 not_full,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pmt_pkg::pmt_result_t out_data
);
  import pmt_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  pmt_result_t      slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = count != '0;
  assign not_full  = count != FULL_COUNT;
  assign out_data  = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // result slots
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== hdl/pmt_section_parser_top.sv =====
// the decode is combinational; the byte transfer that causes a result writes it into the queue
// throughput: one section byte per cycle unless the result queue is full; single-pass decode
// the result queue holds RESULT_DEPTH entries; input stalls only when it is full
// reset: synchronous, active high; clears the section state and empties the queue
module pmt_section_parser_top #(
  parameter int unsigned RESULT_DEPTH = pmt_pkg::RESULT_DEPTH
) (
  input logic         clk,
  input logic         rst,
  pmt_byte_if.sink    section,
  pmt_result_if.source result
);
  import pmt_pkg::*;

  logic        take;
  logic        res_valid;
  logic        not_full;
  pmt_result_t res;
  pmt_result_t head;

  assign section.ready = not_full;
  assign take          = section.valid && not_full;

  // byte decoder and section state
  pmt_parse u_parse (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .byte_value    (section.byte_value),
    .section_start (section.section_start),
    .res_valid     (res_valid),
    .res           (res)
  );

  // result queue decouples input from output stalls
  pmt_result_fifo #(
    .DEPTH (RESULT_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .not_full  (not_full),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (head)
  );

  // output fields
  assign result.kind          = 1'(head.kind);
  assign result.entry_index   = head.entry_index;
  assign result.es_type       = head.es_type;
  assign result.es_pid        = head.es_pid;
  assign result.prog_num      = head.prog_num;
  assign result.version_num   = head.version_num;
  assign result.current_next  = head.current_next;
  assign result.sect_num      = head.sect_num;
  assign result.last_sect_num = head.last_sect_num;
  assign result.pcr_pid       = head.pcr_pid;
  assign result.crc_value     = head.crc_value;
  assign result.malformed     = head.malformed;

endmodule

// ===== hdl/pmt_section_parser_checker.sv =====
`include "assert_macros.svh"

module pmt_section_parser_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_kind,
  input logic [7:0]  out_entry_index,
  input logic [12:0] out_pid,
  input logic [31:0] out_crc,
  input logic        out_malformed
);

  logic        out_stall;
  logic [54:0] out_bits;

  assign out_stall = out_valid && !out_ready;
  assign out_bits  = {out_kind, out_entry_index, out_pid, out_crc, out_malformed};

  // a stalled result stays offered
  `ASSERT_HOLD(a_out_hold, clk, rst, out_stall |=> out_valid, "result dropped while stalled")

  // a stalled result keeps its payload
  `ASSERT_HOLD(a_out_stable, clk, rst, out_stall |=> $stable(out_bits), "stalled result changed")

  // reset empties the result queue
  `ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "result offered after reset")

  // input stalls only while results are waiting
  `ASSERT_HOLD(a_stall_cause, clk, rst, !in_ready |-> out_valid, "input stall, queue empty")

endmodule

bind pmt_section_parser_top pmt_section_parser_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .in_ready        (section.ready),
  .out_valid       (result.valid),
  .out_ready       (result.ready),
  .out_kind        (result.kind),
  .out_entry_index (result.entry_index),
  .out_pid         (result.es_pid),
  .out_crc         (result.crc_value),
  .out_malformed   (result.malformed)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import pmt_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_BYTES = 570;
  localparam int DRAIN_CYCLES = 20;
  localparam int IDLE_PCT     = 19;

  // typed results of the directed rows
  typedef enum logic [1:0] {
    FX_NONE,
    FX_SHORT_SUM,
    FX_ENTRY,
    FX_FULL_SUM
  } fixed_id_t;

  typedef struct packed {
    logic [7:0] b;
    logic       start;
    fixed_id_t  fixed;
  } byte_item_t;

  // directed rows: short section, idle byte, restart, then one full section of extremes
  localparam int N_DIR = 27;
  localparam byte_item_t DIR_TABLE [N_DIR] = '{
    '{8'h02, 1'b1, FX_NONE},
    '{8'hB0, 1'b0, FX_NONE},
    '{8'h00, 1'b0, FX_SHORT_SUM},
    '{8'hFF, 1'b0, FX_NONE},
    '{8'h02, 1'b1, FX_NONE},
    '{8'hB0, 1'b0, FX_NONE},
    '{8'h02, 1'b1, FX_NONE},
    '{8'hF0, 1'b0, FX_NONE},
    '{8'h12, 1'b0, FX_NONE},
    '{8'hFF, 1'b0, FX_NONE},
    '{8'hFF, 1'b0, FX_NONE},
    '{8'hFF, 1'b0, FX_NONE},
    '{8'hFF, 1'b0, FX_NONE},
    '{8'hFF, 1'b0, FX_NONE},
    '{8'hFF, 1'b0, FX_NONE},
    '{8'hFF, 1'b0, FX_NONE},
    '{8'hF0, 1'b0, FX_NONE},
    '{8'h00, 1'b0, FX_NONE},
    '{8'hFF, 1'b0, FX_NONE},
    '{8'hFF, 1'b0, FX_NONE},
    '{8'hFF, 1'b0, FX_NONE},
    '{8'hF0, 1'b0, FX_NONE},
    '{8'h00, 1'b0, FX_ENTRY},
    '{8'hFF, 1'b0, FX_NONE},
    '{8'hFF, 1'b0, FX_NONE},
    '{8'hFF, 1'b0, FX_NONE},
    '{8'hFF, 1'b0, FX_FULL_SUM}
  };

  logic clk;
  logic rst;

  pmt_byte_if   byte_ch ();
  pmt_result_if result_ch ();

  pmt_section_parser_top u_dut (
    .clk     (clk),
    .rst     (rst),
    .section (byte_ch),
    .result  (result_ch)
  );

  // parser model state
  bit          sec_active;
  logic [12:0] pos;
  logic [11:0] sec_len;
  logic [11:0] skip_left;
  logic [2:0]  ent_idx;
  logic [7:0]  ent_type;
  logic [12:0] ent_pid;
  logic [11:0] ent_info;
  logic [7:0]  n_entries;
  logic [63:0] hdr;
  logic [31:0] crc_shift;
  bit          bad;

  byte_item_t  stim_q [$];
  logic [7:0]  sec_bytes [$];
  pmt_result_t due_results [$];
  byte_item_t  cur_item;
  pmt_result_t want;
  pmt_result_t seen;

  int  stim_idx;
  int  n_accepted;
  int  n_random;
  int  n_fail;
  int  n_entry_seen;
  int  n_summary_seen;
  int  n_malformed_seen;
  int  cycle_count;
  bit  quiet;

  // stretch with no idling on either side
  assign quiet = (stim_idx >= 200) && (stim_idx < 400);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void clear_section();
    pos       = '0;
    sec_len   = '0;
    skip_left = '0;
    ent_idx   = ENT_TYPE;
    ent_type  = '0;
    ent_pid   = '0;
    ent_info  = '0;
    n_entries = '0;
    hdr       = '0;
    crc_shift = '0;
    bad       = 1'b0;
  endfunction

  // one section byte through the parser model; returns 1 when a result is due
  function automatic bit parse_byte(input logic [7:0] b, input logic start,
                                    output pmt_result_t res);
    logic [12:0] p;
    logic [7:0]  ver_byte;
    bit          got;
    got = 1'b0;
    res = '0;
    if (start) begin
      clear_section();
      sec_active = 1'b1;
    end
    if (!sec_active) return 1'b0;
    p = pos;
    crc_shift = {crc_shift[23:0], b};

    // header fields
    if (p == POS_LEN_HI) begin
      sec_len = {b[3:0], 8'h00};
    end else if (p == POS_LEN_LO) begin
      sec_len = sec_len | {4'h0, b};
      if (sec_len < MIN_SECTION_LEN) bad = 1'b1;
    end else if (p >= POS_PROG_HI && p <= POS_PCR_LO) begin
      hdr[8 * (9 - int'(p)) +: 8] = b;
    end else if (p == POS_INFO_HI) begin
      skip_left = {b[3:0], 8'h00};
    end else if (p == POS_INFO_LO) begin
      skip_left = skip_left | {4'h0, b};
      ent_idx = ENT_TYPE;
    end else if (p >= POS_BODY) begin
      // crc region drops whatever is pending
      if ({1'b0, p} + 14'd1 >= {2'b00, sec_len}) begin
        if (skip_left != '0 || ent_idx != ENT_TYPE) bad = 1'b1;
        skip_left = '0;
        ent_idx = ENT_TYPE;
      end else if (skip_left != '0) begin
        skip_left = skip_left - 12'd1;
      end else begin
        case (ent_idx)
          ENT_TYPE:    ent_type = b;
          ENT_PID_HI:  ent_pid = {b[4:0], 8'h00};
          ENT_PID_LO:  ent_pid = ent_pid | {5'h00, b};
          ENT_INFO_HI: ent_info = {b[3:0], 8'h00};
          default:     ent_info = ent_info | {4'h0, b};
        endcase
        // entry complete
        if (ent_idx == ENT_INFO_LO) begin
          res.kind = KIND_ENTRY;
          res.entry_index = n_entries;
          res.es_type = ent_type;
          res.es_pid = ent_pid;
          got = 1'b1;
          n_entries = n_entries + 8'd1;
          skip_left = ent_info;
          ent_idx = ENT_TYPE;
        end else begin
          ent_idx = ent_idx + 3'd1;
        end
      end
    end

    // summary on the last crc byte
    if (p >= POS_LEN_LO && p == {1'b0, sec_len} + 13'd2) begin
      ver_byte = hdr[39:32];
      res = '0;
      res.kind = KIND_SUMMARY;
      res.entry_index = n_entries;
      res.prog_num = hdr[55:40];
      res.version_num = ver_byte[5:1];
      res.current_next = ver_byte[0];
      res.sect_num = hdr[31:24];
      res.last_sect_num = hdr[23:16];
      res.pcr_pid = hdr[12:0];
      res.crc_value = crc_shift;
      res.malformed = bad;
      got = 1'b1;
      sec_active = 1'b0;
    end
    pos = pos + 13'd1;
    return got;
  endfunction

  function automatic pmt_result_t fixed_result(input fixed_id_t id);
    pmt_result_t r;
    r = '0;
    case (id)
      FX_SHORT_SUM: begin
        r.kind = KIND_SUMMARY;
        r.crc_value = 32'h0002_B000;
        r.malformed = 1'b1;
      end
      FX_ENTRY: begin
        r.kind = KIND_ENTRY;
        r.es_type = 8'hFF;
        r.es_pid = 13'h1FFF;
      end
      default: begin
        r.kind = KIND_SUMMARY;
        r.entry_index = 8'd1;
        r.prog_num = 16'hFFFF;
        r.version_num = 5'h1F;
        r.current_next = 1'b1;
        r.sect_num = 8'hFF;
        r.last_sect_num = 8'hFF;
        r.pcr_pid = 13'h1FFF;
        r.crc_value = 32'hFFFF_FFFF;
      end
    endcase
    return r;
  endfunction

  // accepted byte: advance the model and queue what it produces
  task automatic take_byte(input byte_item_t it);
    pmt_result_t r;
    bit          got;
    got = parse_byte(it.b, it.start, r);
    if (it.fixed != FX_NONE) due_results.push_back(fixed_result(it.fixed));
    else if (got) due_results.push_back(r);
  endtask

  task automatic push_byte(input logic [7:0] b, input logic start);
    byte_item_t it;
    it.b = b;
    it.start = start;
    it.fixed = FX_NONE;
    stim_q.push_back(it);
  endtask

  // well-formed section into sec_bytes, with its length field
  task automatic build_section(input int n_ent, input int prog_info, input int max_info,
                               output logic [11:0] len);
    int info;
    sec_bytes.delete();
    sec_bytes.push_back(8'($urandom));
    sec_bytes.push_back(8'h00);
    sec_bytes.push_back(8'h00);
    repeat (7) sec_bytes.push_back(8'($urandom));
    sec_bytes.push_back({4'($urandom), 4'(prog_info >> 8)});
    sec_bytes.push_back(8'(prog_info));
    repeat (prog_info) sec_bytes.push_back(8'($urandom));
    repeat (n_ent) begin
      info = $urandom_range(0, max_info);
      repeat (3) sec_bytes.push_back(8'($urandom));
      sec_bytes.push_back({4'($urandom), 4'(info >> 8)});
      sec_bytes.push_back(8'(info));
      repeat (info) sec_bytes.push_back(8'($urandom));
    end
    len = 12'(sec_bytes.size() + 1);
    repeat (4) sec_bytes.push_back(8'($urandom));
    sec_bytes[1] = {sec_bytes[1][7:4], len[11:8]};
    sec_bytes[2] = len[7:0];
  endtask

  // first count bytes of the section, padded with random bytes
  task automatic emit_section(input int count);
    for (int i = 0; i < count; i++) begin
      push_byte((i < sec_bytes.size()) ? sec_bytes[i] : 8'($urandom), i == 0);
    end
    n_random += count;
  endtask

  task automatic add_random_section();
    logic [11:0] len;
    logic [11:0] stated;
    int          roll;
    int          prog_info;
    prog_info = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 3);
    build_section($urandom_range(0, 4), prog_info,
                  ($urandom_range(0, 9) == 0) ? 30 : 3, len);
    roll = $urandom_range(0, 99);
    if (roll >= 92) begin
      // cut short, the next start abandons it
      emit_section($urandom_range(1, int'(len) + 2));
    end else begin
      stated = len;
      if (roll >= 85) stated = 12'($urandom_range(0, 12));
      else if (roll >= 75) stated = 12'(int'(len) + $urandom_range(0, 10) - 5);
      sec_bytes[1] = {sec_bytes[1][7:4], stated[11:8]};
      sec_bytes[2] = stated[7:0];
      emit_section(int'(stated) + 3);
    end
    // bytes outside any section
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      n_fail++;
    end
  endtask

  // result side: random stalls and comparison against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
      if (result_ch.valid && result_ch.ready) begin
        seen.kind = pmt_kind_t'(result_ch.kind);
        seen.entry_index = result_ch.entry_index;
        seen.es_type = result_ch.es_type;
        seen.es_pid = result_ch.es_pid;
        seen.prog_num = result_ch.prog_num;
        seen.version_num = result_ch.version_num;
        seen.current_next = result_ch.current_next;
        seen.sect_num = result_ch.sect_num;
        seen.last_sect_num = result_ch.last_sect_num;
        seen.pcr_pid = result_ch.pcr_pid;
        seen.crc_value = result_ch.crc_value;
        seen.malformed = result_ch.malformed;
        if (seen.kind == KIND_SUMMARY) n_summary_seen++;
        else n_entry_seen++;
        if (seen.malformed === 1'b1) n_malformed_seen++;
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0d index %0d",
                   $time, seen.kind, seen.entry_index);
          n_fail++;
        end else begin
          want = due_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(seen.kind));
          check_field("entry_index", 32'(want.entry_index), 32'(seen.entry_index));
          check_field("es_type", 32'(want.es_type), 32'(seen.es_type));
          check_field("es_pid", 32'(want.es_pid), 32'(seen.es_pid));
          check_field("prog_num", 32'(want.prog_num), 32'(seen.prog_num));
          check_field("version_num", 32'(want.version_num), 32'(seen.version_num));
          check_field("current_next", 32'(want.current_next), 32'(seen.current_next));
          check_field("sect_num", 32'(want.sect_num), 32'(seen.sect_num));
          check_field("last_sect_num", 32'(want.last_sect_num),
                      32'(seen.last_sect_num));
          check_field("pcr_pid", 32'(want.pcr_pid), 32'(seen.pcr_pid));
          check_field("crc_value", want.crc_value, seen.crc_value);
          check_field("malformed", 32'(want.malformed), 32'(seen.malformed));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL pmt_section_parser_top");
      $finish;
    end
  end

  // stimulus and byte side
  initial begin
    byte_ch.valid = 1'b0;
    byte_ch.byte_value = '0;
    byte_ch.section_start = 1'b0;
    rst = 1'b1;
    stim_idx = 0;
    n_accepted = 0;
    n_random = 0;
    n_fail = 0;
    n_entry_seen = 0;
    n_summary_seen = 0;
    n_malformed_seen = 0;
    sec_active = 1'b0;
    clear_section();

    // directed rows, then random sections
    for (int i = 0; i < N_DIR; i++) stim_q.push_back(DIR_TABLE[i]);
    while (n_random < RANDOM_BYTES) add_random_section();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // byte transfers with random gaps
    while (n_accepted < stim_q.size()) begin
      @(posedge clk);
      if (byte_ch.valid && byte_ch.ready) begin
        take_byte(cur_item);
        n_accepted++;
      end
      if (!byte_ch.valid || byte_ch.ready) begin
        if (stim_idx < stim_q.size() && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
          cur_item = stim_q[stim_idx];
          stim_idx++;
          byte_ch.valid <= 1'b1;
          byte_ch.byte_value <= cur_item.b;
          byte_ch.section_start <= cur_item.start;
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end

    // drain
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("fed %0d section bytes incl. restarts, short and overrun sections, idle bytes",
             n_accepted);
    $display("checked %0d entry results and %0d section summaries, %0d flagged malformed",
             n_entry_seen, n_summary_seen, n_malformed_seen);
    if (n_fail == 0) $display("PASS pmt_section_parser_top");
    else $display("FAIL pmt_section_parser_top");
    $finish;
  end

endmodule
